FILE: hdl/adsr_eg_pkg.sv
// Package for the ADSR envelope generator: widths, fixed-point constants,
// request, stage and register codes, mode flag bits, and the 32-bit saturation helper.
// No dependencies; compiled first.
package adsr_eg_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS = 30;
   localparam int LEVEL_W   = 32;
   localparam int COEF_W    = 31;
   localparam int REQ_W     = 3;
   localparam int STAGE_W   = 3;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int PROD_W    = 2 * LEVEL_W;
   // offset + floor(level * coef): magnitude stays below 2^33
   localparam int SUM_W     = LEVEL_W + 3;

   localparam logic signed [SUM_W-1:0]   ONE_S = SUM_W'(1) << FRAC_BITS;
   localparam logic signed [LEVEL_W-1:0] ONE_L = LEVEL_W'(1) << FRAC_BITS;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
   localparam logic [REQ_W-1:0] REQ_NOTE_ON   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_NOTE_OFF  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_STOP      = 3'd4;
   localparam logic [REQ_W-1:0] REQ_SHUTDOWN  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_PEDAL_ON  = 3'd6;
   localparam logic [REQ_W-1:0] REQ_PEDAL_OFF = 3'd7;

   // Envelope stage codes
   localparam logic [STAGE_W-1:0] ST_OFF      = 3'd0;
   localparam logic [STAGE_W-1:0] ST_ATTACK   = 3'd1;
   localparam logic [STAGE_W-1:0] ST_DECAY    = 3'd2;
   localparam logic [STAGE_W-1:0] ST_SUSTAIN  = 3'd3;
   localparam logic [STAGE_W-1:0] ST_RELEASE  = 3'd4;
   localparam logic [STAGE_W-1:0] ST_SHUTDOWN = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_OFFS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_COEF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_OFFS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_OFFS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 3'd7;

   // Mode flag bit positions
   localparam int MODE_RTZ    = 0;
   localparam int MODE_LEGATO = 1;
   localparam int MODE_RAMP   = 2;

   // Clamp a wide signed value to 32-bit signed
   function automatic logic signed [LEVEL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [LEVEL_W-1:0] r;
      if (v[SUM_W-1:LEVEL_W-1] == '0 || v[SUM_W-1:LEVEL_W-1] == '1) begin
         r = v[LEVEL_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(LEVEL_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

FILE: hdl/adsr_eg_if.sv
// Valid/ready channel interfaces of the ADSR envelope generator: request,
// result and register write channels.
// Depends on adsr_eg_pkg.
interface adsr_eg_req_if;
   import adsr_eg_pkg::*;
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [COEF_W-1:0]   shutdown_rate;

   modport source (output valid, output req_type, output shutdown_rate, input ready);
   modport sink   (input valid, input req_type, input shutdown_rate, output ready);
endinterface

interface adsr_eg_rsp_if;
   import adsr_eg_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [LEVEL_W-1:0]  envelope_level;
   logic signed [LEVEL_W-1:0]  biased_level;
   logic [STAGE_W-1:0]         stage;
   logic                       active;
   logic                       can_release;

   modport source (output valid, output envelope_level, output biased_level, output stage,
                   output active, output can_release, input ready);
   modport sink   (input valid, input envelope_level, input biased_level, input stage,
                   input active, input can_release, output ready);
endinterface

interface adsr_eg_csr_if;
   import adsr_eg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/adsr_envelope_generator_top.sv
// Exponential ADSR envelope generator. One item is accepted every cycle when the
// result side keeps up. An item passes through the input register, then the result
// register, before its result is on the result port. The rate is set by the single
// multiply-add loop on the level register: one 32x31 multiply, an add, compare
// and clamp per cycle. Register writes are always accepted and must happen only
// while no item is in flight. Depends on adsr_eg_pkg and adsr_eg_if.
module adsr_envelope_generator_top (
   input  logic              clock,
   input  logic              reset,
   adsr_eg_req_if.sink       req_ch,
   adsr_eg_rsp_if.source     rsp_ch,
   adsr_eg_csr_if.sink       csr_ch
);
   import adsr_eg_pkg::*;

   // Configuration registers
   logic [COEF_W-1:0]         attack_coef_ff;
   logic signed [LEVEL_W-1:0] attack_offs_ff;
   logic [COEF_W-1:0]         decay_coef_ff;
   logic signed [LEVEL_W-1:0] decay_offs_ff;
   logic [COEF_W-1:0]         release_coef_ff;
   logic signed [LEVEL_W-1:0] release_offs_ff;
   logic [COEF_W-1:0]         sustain_ff;
   logic [MODE_W-1:0]         mode_ff;

   // Input register
   logic                      in_valid_ff;
   logic [REQ_W-1:0]          in_type_ff;
   logic [COEF_W-1:0]         in_rate_ff;

   // Envelope state
   logic [STAGE_W-1:0]        stage_ff,  stage_in;
   logic signed [LEVEL_W-1:0] level_ff,  level_in;
   logic                      pend_ff,   pend_in;
   logic                      pedal_ff,  pedal_in;
   logic signed [LEVEL_W-1:0] step_ff,   step_in;

   // Result register
   logic                      out_valid_ff;
   logic signed [LEVEL_W-1:0] out_level_ff;
   logic signed [LEVEL_W-1:0] out_biased_ff;
   logic [STAGE_W-1:0]        out_stage_ff;
   logic                      out_active_ff;
   logic                      out_canrel_ff;

   logic                      advance;
   logic                      fire;
   logic                      req_fire;
   logic [COEF_W-1:0]         coef_sel;
   logic signed [LEVEL_W-1:0] offs_sel;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]   mq;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   sus_s;
   logic signed [LEVEL_W-1:0] sus_l;
   logic                      rtz;
   logic                      legato;
   logic                      ramp;
   logic                      level_pos;

   assign rtz    = mode_ff[MODE_RTZ];
   assign legato = mode_ff[MODE_LEGATO];
   assign ramp   = mode_ff[MODE_RAMP];
   assign sus_l  = $signed({1'b0, sustain_ff});
   assign sus_s  = $signed({{(SUM_W-COEF_W){1'b0}}, sustain_ff});
   assign level_pos = !level_ff[LEVEL_W-1] && (level_ff != '0);

   // Handshake: result register frees when empty or taken
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_coef_ff  <= '0;
         attack_offs_ff  <= ONE_L;
         decay_coef_ff   <= '0;
         decay_offs_ff   <= '0;
         release_coef_ff <= '0;
         release_offs_ff <= '0;
         sustain_ff      <= COEF_W'(ONE_L);
         mode_ff         <= MODE_W'(1);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ATTACK_COEF:  attack_coef_ff  <= csr_ch.data[COEF_W-1:0];
            CSR_ATTACK_OFFS:  attack_offs_ff  <= $signed(csr_ch.data);
            CSR_DECAY_COEF:   decay_coef_ff   <= csr_ch.data[COEF_W-1:0];
            CSR_DECAY_OFFS:   decay_offs_ff   <= $signed(csr_ch.data);
            CSR_RELEASE_COEF: release_coef_ff <= csr_ch.data[COEF_W-1:0];
            CSR_RELEASE_OFFS: release_offs_ff <= $signed(csr_ch.data);
            CSR_SUSTAIN:      sustain_ff      <= csr_ch.data[COEF_W-1:0];
            CSR_MODE:         mode_ff         <= csr_ch.data[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff <= req_ch.req_type;
         in_rate_ff <= req_ch.shutdown_rate;
      end
   end

   // Multiplier operand and offset select
   always_comb begin
      coef_sel = '0;
      offs_sel = '0;
      if (in_type_ff == REQ_SHUTDOWN) begin
         coef_sel = in_rate_ff;
      end else begin
         case (stage_ff)
            ST_ATTACK: begin
               coef_sel = attack_coef_ff;
               offs_sel = attack_offs_ff;
            end
            ST_DECAY: begin
               coef_sel = decay_coef_ff;
               offs_sel = decay_offs_ff;
            end
            ST_RELEASE: begin
               coef_sel = release_coef_ff;
               offs_sel = release_offs_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // floor(level * coef / 2^FRAC_BITS) via arithmetic shift, then the add
   assign prod = level_ff * $signed({1'b0, coef_sel});
   assign mq   = $signed(SUM_W'(prod >>> FRAC_BITS));
   assign sum  = $signed({{(SUM_W-LEVEL_W){offs_sel[LEVEL_W-1]}}, offs_sel}) + mq;

   // Next state for the item in the input register
   always_comb begin
      logic signed [LEVEL_W-1:0] sd_lvl;
      stage_in = stage_ff;
      level_in = level_ff;
      pend_in  = pend_ff;
      pedal_in = pedal_ff;
      step_in  = step_ff;
      sd_lvl   = sat32($signed({{(SUM_W-LEVEL_W){level_ff[LEVEL_W-1]}}, level_ff})
                     + $signed({{(SUM_W-LEVEL_W){step_ff[LEVEL_W-1]}}, step_ff}));
      case (in_type_ff)
         REQ_TICK: begin
            case (stage_ff)
               ST_OFF: begin
                  if (rtz) level_in = '0;
               end
               ST_ATTACK: begin
                  if (sum >= ONE_S || attack_coef_ff == '0) begin
                     level_in = ONE_L;
                     stage_in = ST_DECAY;
                  end else begin
                     level_in = sat32(sum);
                  end
               end
               ST_DECAY: begin
                  if (sum <= sus_s || decay_coef_ff == '0) begin
                     level_in = sus_l;
                     // ramp mode: note off right at the sustain level
                     if (!ramp) begin
                        stage_in = ST_SUSTAIN;
                     end else if (pedal_ff) begin
                        pend_in = 1'b1;
                     end else begin
                        stage_in = (sustain_ff != '0) ? ST_RELEASE : ST_OFF;
                     end
                  end else begin
                     level_in = sat32(sum);
                  end
               end
               ST_SUSTAIN: begin
                  level_in = sus_l;
               end
               ST_RELEASE: begin
                  if (pedal_ff) begin
                     level_in = sus_l;
                  end else if (sum <= $signed(SUM_W'(0)) || release_coef_ff == '0) begin
                     level_in = '0;
                     stage_in = ST_OFF;
                  end else begin
                     level_in = sat32(sum);
                  end
               end
               ST_SHUTDOWN: begin
                  if (!rtz) begin
                     stage_in = ST_OFF;
                  end else if (sd_lvl <= $signed(LEVEL_W'(0))) begin
                     level_in = '0;
                     stage_in = ST_OFF;
                  end else begin
                     level_in = sd_lvl;
                  end
               end
               default: stage_in = ST_OFF;
            endcase
         end
         REQ_NOTE_ON: begin
            if (!legato || stage_ff == ST_OFF || stage_ff == ST_RELEASE) begin
               pend_in  = 1'b0;
               stage_in = ST_ATTACK;
               if (rtz) level_in = '0;
            end
         end
         REQ_NOTE_OFF: begin
            if (pedal_ff) begin
               pend_in = 1'b1;
            end else begin
               stage_in = level_pos ? ST_RELEASE : ST_OFF;
            end
         end
         REQ_RELEASE: begin
            if (stage_ff == ST_SUSTAIN) stage_in = ST_RELEASE;
         end
         REQ_STOP: begin
            stage_in = ST_OFF;
         end
         REQ_SHUTDOWN: begin
            if (!legato) begin
               step_in  = sat32(-mq);
               stage_in = ST_SHUTDOWN;
               pedal_in = 1'b0;
               pend_in  = 1'b0;
            end
         end
         REQ_PEDAL_ON: begin
            pedal_in = 1'b1;
         end
         default: begin
            // pedal off: a held note off now takes effect
            pedal_in = 1'b0;
            if (pend_ff) begin
               pend_in  = 1'b0;
               stage_in = level_pos ? ST_RELEASE : ST_OFF;
            end
         end
      endcase
   end

   // Envelope state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_OFF;
         level_ff <= '0;
         pend_ff  <= 1'b0;
         pedal_ff <= 1'b0;
         step_ff  <= '0;
      end else if (fire) begin
         stage_ff <= stage_in;
         level_ff <= level_in;
         pend_ff  <= pend_in;
         pedal_ff <= pedal_in;
         step_ff  <= step_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_level_ff  <= level_in;
         out_biased_ff <= sat32($signed({{(SUM_W-LEVEL_W){level_in[LEVEL_W-1]}}, level_in})
                                - sus_s);
         out_stage_ff  <= stage_in;
         out_active_ff <= stage_in != ST_RELEASE && stage_in != ST_OFF && !pend_in;
         out_canrel_ff <= stage_in != ST_RELEASE && stage_in != ST_SHUTDOWN
                          && stage_in != ST_OFF && !pend_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.envelope_level = out_level_ff;
   assign rsp_ch.biased_level   = out_biased_ff;
   assign rsp_ch.stage          = out_stage_ff;
   assign rsp_ch.active         = out_active_ff;
   assign rsp_ch.can_release    = out_canrel_ff;

   // Checks
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted item did not reach the input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_type_ff) && $stable(level_ff)))
      else $error("stalled item or state changed");

   a_canrel_active: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_canrel_ff || out_active_ff))
      else $error("can_release set without active");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (stage_ff == ST_OFF && !pend_ff && !pedal_ff && !out_valid_ff))
      else $error("state not cleared by reset");

endmodule
